FILE: rtl/core/crv_pkg.sv
// Package for the settings record validator: constants, status codes and
// the controller/datapath command and status structs. No dependencies.
`default_nettype none
package crv_pkg;
   localparam logic [31:0] CRC_POLY     = 32'hEDB88320;
   localparam logic [31:0] REC_MAGIC    = 32'h4D4B4346;
   localparam logic [31:0] REC_COMMIT   = 32'h434D4954;
   localparam logic [31:0] REC_RESERVED = 32'hFE000000;
   localparam logic [15:0] REC_WORDS    = 16'd8;
   localparam logic [2:0]  REC_CRC_IDX  = 3'd6;
   localparam logic [2:0]  REC_LAST_IDX = 3'd7;
   localparam logic [1:0]  NO_SLOT      = 2'd2;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_MAGIC    = 3'd1;
   localparam logic [2:0] ST_HEADER   = 3'd2;
   localparam logic [2:0] ST_CRC      = 3'd3;
   localparam logic [2:0] ST_RESERVED = 3'd4;
   localparam logic [2:0] ST_SETTINGS = 3'd5;
   localparam logic [2:0] ST_READ     = 3'd6;

   // controller -> datapath
   typedef struct packed {
      logic load;       // capture input word and run per-word checks
      logic crc_step;   // one CRC bit step
      logic div_start;  // start rounded division
      logic div_step;   // one division step
      logic finish;     // settle status, update selection, load output
      logic fail;       // read failure result
   } crv_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [2:0] pos;
      logic       div_done;
   } crv_sts_type;

   typedef struct packed {
      logic [2:0]  record_status;
      logic        record_slot;
      logic [31:0] generation;
      logic [15:0] counts_per_rev;
      logic [15:0] cycles_per_rev;
      logic [15:0] zero_position;
      logic [15:0] observed_quarter;
      logic signed [15:0] quarter_error;
      logic signed [7:0]  direction;
      logic        alignment_valid;
      logic [1:0]  selected_slot;
      logic [1:0]  passed_slots;
   } crv_rsp_type;

   typedef struct packed {
      logic [31:0] word;
      logic        slot;
      logic        read_failed;
      logic        new_scan;
   } crv_req_type;
endpackage
`default_nettype wire

FILE: rtl/core/crv_if.sv
// Valid/ready channel interfaces for request and response items.
// Depends on crv_pkg.
`default_nettype none
interface crv_req_if;
   logic                valid;
   logic                ready;
   crv_pkg::crv_req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface crv_rsp_if;
   logic                valid;
   logic                ready;
   crv_pkg::crv_rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/config_record_validator_unit.sv
// Top level of the settings record validator: schema register, controller
// and datapath. Depends on crv_pkg, crv_if, crv_ctrl and crv_datapath.
//
// Usage: feed the eight words of a record, in order, on the req channel,
// each with its slot, read-failure flag and new-scan flag. One rsp item
// comes out per record, after the commit word, or at once on a read failure.
// Words 0 to 5 each take a transfer and then 32 bit steps of the serial CRC
// unit; word 6 takes only the transfer. After word 7 the 17-step restoring
// divider runs, and then the result is loaded into the output register.
// A read failure gives its result in the next cycle.
// The csr_ port writes the expected schema version (reset value 1); write
// only while idle. Reset clears the record position, fault, CRC and slot
// selection. When the receiver stalls, the result is held in the output
// register; words are still accepted, but a read failure or the next
// finished record waits until the held result is taken.
`default_nettype none
module config_record_validator_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   crv_req_if.sink          req,
   crv_rsp_if.source        rsp,
   input  wire logic        csr_write_enable,
   input  wire logic [15:0] csr_write_data
);
   import crv_pkg::*;

   logic [15:0] schema_ff;
   crv_cmd_type cmd;
   crv_sts_type sts;

   always_ff @(posedge clock) begin
      if (reset) schema_ff <= 16'd1;
      else if (csr_write_enable) schema_ff <= csr_write_data;
   end

   crv_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_read_failed(req.data.read_failed),
      .req_ready(req.ready), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .sts(sts), .cmd(cmd)
   );

   crv_datapath u_dp (
      .clock(clock), .reset(reset), .schema_version(schema_ff),
      .cmd(cmd), .sts(sts), .req(req.data), .rsp(rsp.data)
   );
endmodule
`default_nettype wire

FILE: rtl/core/crv_datapath.sv
// Datapath: word capture, bit-serial CRC, restoring divider, settings check,
// slot selection and output register. Depends on crv_pkg.
`default_nettype none
module crv_datapath (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [15:0]          schema_version,
   input  wire crv_pkg::crv_cmd_type cmd,
   output crv_pkg::crv_sts_type      sts,
   input  wire crv_pkg::crv_req_type req,
   output crv_pkg::crv_rsp_type      rsp
);
   import crv_pkg::*;

   logic [2:0]  pos_ff, pos_in;
   logic [31:0] crc_ff, crc_in;
   logic [7:0]  cbyte_ff, cbyte_in;   // remaining byte bits to xor in
   logic [4:0]  ccnt_ff, ccnt_in;     // CRC bit steps done in current word
   logic [31:0] cword_ff, cword_in;
   logic [2:0]  fault_ff, fault_in;
   logic [31:0] gen_ff, geo_ff, aln_ff, flg_ff;
   logic [31:0] gen_in, geo_in, aln_in, flg_in;
   logic [1:0]  csel_ff, csel_in;
   logic [31:0] cgen_ff, cgen_in;
   logic [1:0]  mask_ff, mask_in;
   logic        slot_ff, slot_in;
   logic [16:0] rem_ff, rem_in;
   logic [16:0] quo_ff, quo_in;
   logic [4:0]  dcnt_ff, dcnt_in;
   crv_rsp_type rsp_ff, rsp_in;

   // settings check operands
   logic [15:0] cpr, cyc, zero, oq;
   logic [17:0] den;
   logic [7:0]  dir;
   logic        aval, pre_ok, set_ok;
   logic [16:0] dividend, rem_sh;
   logic [17:0] rem_try;
   logic [17:0] err;
   logic        sel_upd;
   logic [31:0] gdiff;
   logic [2:0]  status;
   logic        crc_b;
   logic [2:0]  fnew;
   logic [2:0]  wfault;

   assign cpr  = geo_ff[15:0];
   assign cyc  = geo_ff[31:16];
   assign zero = aln_ff[15:0];
   assign oq   = aln_ff[31:16];
   assign dir  = flg_ff[23:16];
   assign aval = flg_ff[24];
   assign den  = {cyc, 2'b00};
   assign dividend = {1'b0, cpr} + {1'b0, den[16:1]};
   assign rem_sh  = {rem_ff[15:0], dividend[5'd16 - dcnt_ff]};
   assign rem_try = {1'b0, rem_sh} - den;

   always_comb begin
      pre_ok = 1'b1;
      if (cpr < 16'd8 || cyc == 16'd0) pre_ok = 1'b0;
      else if (den > {3'b000, cpr[15:1]}) pre_ok = 1'b0;
      set_ok = 1'b0;
      err = {2'b00, oq} - {1'b0, quo_ff};
      if (!pre_ok) set_ok = 1'b0;
      else if (!aval)
         set_ok = zero == 16'd0 && oq == 16'd0 && flg_ff[15:0] == 16'd0 && dir == 8'd0;
      else if (zero >= cpr || oq == 16'd0 || oq >= {1'b0, cpr[15:1]} ||
               (dir != 8'd1 && dir != 8'hFF))
         set_ok = 1'b0;
      else
         // error must fit 16 signed bits and equal the stored error
         set_ok = (err[17:15] == 3'b000 || err[17:15] == 3'b111) &&
                  err[15:0] == flg_ff[15:0];
   end

   always_comb begin
      wfault = ST_OK;
      case (pos_ff)
         3'd0: if (req.word != REC_MAGIC) wfault = ST_MAGIC;
         3'd1: if (req.word[31:16] != schema_version || req.word[15:0] != REC_WORDS)
                  wfault = ST_HEADER;
         3'd5: if ((req.word & REC_RESERVED) != 32'd0) wfault = ST_RESERVED;
         3'd6: if (req.word != ~crc_ff) wfault = ST_CRC;
         3'd7: if (req.word != REC_COMMIT) wfault = ST_MAGIC;
         default: wfault = ST_OK;
      endcase
      fnew = fault_ff;
      if (wfault != ST_OK && (fault_ff == ST_OK || wfault < fault_ff)) fnew = wfault;
   end

   assign status = (fault_ff == ST_OK && !set_ok) ? ST_SETTINGS : fault_ff;
   assign gdiff  = gen_ff - cgen_ff;
   assign crc_b  = crc_ff[0] ^ cbyte_ff[0];

   always_comb begin
      pos_in = pos_ff; crc_in = crc_ff; cbyte_in = cbyte_ff; ccnt_in = ccnt_ff;
      cword_in = cword_ff; fault_in = fault_ff; gen_in = gen_ff; geo_in = geo_ff;
      aln_in = aln_ff; flg_in = flg_ff; csel_in = csel_ff; cgen_in = cgen_ff;
      mask_in = mask_ff; slot_in = slot_ff; rem_in = rem_ff; quo_in = quo_ff;
      dcnt_in = dcnt_ff; rsp_in = rsp_ff; sel_upd = 1'b0;

      if ((cmd.load || cmd.fail) && pos_ff == 3'd0 && req.new_scan) begin
         csel_in = NO_SLOT; cgen_in = 32'd0; mask_in = 2'b00;
      end
      if (cmd.fail) begin
         rsp_in = '0;
         rsp_in.record_status = ST_READ;
         rsp_in.record_slot = req.slot;
         rsp_in.selected_slot = csel_in;
         rsp_in.passed_slots = mask_in;
         pos_in = 3'd0; crc_in = '1; fault_in = ST_OK;
      end else if (cmd.load) begin
         slot_in = req.slot;
         fault_in = fnew;
         cword_in = req.word;
         cbyte_in = req.word[7:0];
         ccnt_in = 5'd0;
         case (pos_ff)
            3'd2: gen_in = req.word;
            3'd3: geo_in = req.word;
            3'd4: aln_in = req.word;
            3'd5: flg_in = req.word;
            default: ;
         endcase
         if (pos_ff != REC_LAST_IDX) pos_in = pos_ff + 3'd1;
      end
      if (cmd.crc_step) begin
         crc_in = {1'b0, crc_ff[31:1]} ^ (crc_b ? CRC_POLY : 32'd0);
         ccnt_in = ccnt_ff + 5'd1;
         cbyte_in = {1'b0, cbyte_ff[7:1]};
         if (ccnt_ff[2:0] == 3'd7) begin
            case (ccnt_ff[4:3])
               2'd0: cbyte_in = cword_ff[15:8];
               2'd1: cbyte_in = cword_ff[23:16];
               2'd2: cbyte_in = cword_ff[31:24];
               default: cbyte_in = 8'd0;
            endcase
         end
      end
      if (cmd.div_start) begin
         rem_in = '0; quo_in = '0; dcnt_in = 5'd0;
      end else if (cmd.div_step) begin
         if (!rem_try[17]) begin
            rem_in = rem_try[16:0]; quo_in = {quo_ff[15:0], 1'b1};
         end else begin
            rem_in = rem_sh; quo_in = {quo_ff[15:0], 1'b0};
         end
         dcnt_in = dcnt_ff + 5'd1;
      end
      if (cmd.finish) begin
         if (status == ST_OK) begin
            mask_in = mask_ff | (slot_ff ? 2'b10 : 2'b01);
            if (csel_ff == NO_SLOT || (gdiff != 32'd0 && !gdiff[31])) sel_upd = 1'b1;
         end
         if (sel_upd) begin
            csel_in = {1'b0, slot_ff}; cgen_in = gen_ff;
         end
         rsp_in.record_status = status;
         rsp_in.record_slot = slot_ff;
         rsp_in.generation = gen_ff;
         rsp_in.counts_per_rev = cpr;
         rsp_in.cycles_per_rev = cyc;
         rsp_in.zero_position = zero;
         rsp_in.observed_quarter = oq;
         rsp_in.quarter_error = flg_ff[15:0];
         rsp_in.direction = dir;
         rsp_in.alignment_valid = aval;
         rsp_in.selected_slot = csel_in;
         rsp_in.passed_slots = mask_in;
         pos_in = 3'd0; crc_in = '1; fault_in = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= 3'd0; crc_ff <= '1; fault_ff <= ST_OK;
         gen_ff <= '0; geo_ff <= '0; aln_ff <= '0; flg_ff <= '0;
         csel_ff <= NO_SLOT; cgen_ff <= '0; mask_ff <= 2'b00;
         ccnt_ff <= 5'd0; dcnt_ff <= 5'd0;
      end else begin
         pos_ff <= pos_in; crc_ff <= crc_in; fault_ff <= fault_in;
         gen_ff <= gen_in; geo_ff <= geo_in; aln_ff <= aln_in; flg_ff <= flg_in;
         csel_ff <= csel_in; cgen_ff <= cgen_in; mask_ff <= mask_in;
         ccnt_ff <= ccnt_in; dcnt_ff <= dcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      cbyte_ff <= cbyte_in; cword_ff <= cword_in; slot_ff <= slot_in;
      rem_ff <= rem_in; quo_ff <= quo_in; rsp_ff <= rsp_in;
   end

   assign sts.pos = pos_ff;
   assign sts.div_done = dcnt_ff == 5'd17;
   assign rsp = rsp_ff;
endmodule
`default_nettype wire

FILE: rtl/core/crv_ctrl.sv
// Controller: sequences word load, 32 CRC bit steps, the 17-step divide and
// the result handshake. Depends on crv_pkg.
`default_nettype none
module crv_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_read_failed,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire crv_pkg::crv_sts_type sts,
   output crv_pkg::crv_cmd_type      cmd
);
   import crv_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_CRC  = 3'd1;
   localparam logic [2:0] S_DIVI = 3'd2;
   localparam logic [2:0] S_DIV  = 3'd3;
   localparam logic [2:0] S_FIN  = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;
   logic       vld_ff, vld_in;
   logic       take, last;

   // only a read failure needs the output register free at transfer time
   assign req_ready = state_ff == S_IDLE && (!vld_ff || rsp_ready || !req_read_failed);
   assign take = req_valid && req_ready;
   assign last = sts.pos == REC_LAST_IDX;
   assign rsp_valid = vld_ff;

   always_comb begin
      state_in = state_ff; cnt_in = cnt_ff; cmd = '0;
      vld_in = vld_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: if (take) begin
            if (req_read_failed) begin
               cmd.fail = 1'b1; vld_in = 1'b1;
            end else begin
               cmd.load = 1'b1;
               cnt_in = 5'd0;
               if (sts.pos < REC_CRC_IDX) state_in = S_CRC;
               else if (last) state_in = S_DIVI;
            end
         end
         S_CRC: begin
            cmd.crc_step = 1'b1;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) state_in = S_IDLE;
         end
         S_DIVI: begin
            cmd.div_start = 1'b1; state_in = S_DIV;
         end
         S_DIV: begin
            if (sts.div_done) state_in = S_FIN;
            else cmd.div_step = 1'b1;
         end
         S_FIN: if (!vld_ff || rsp_ready) begin
            cmd.finish = 1'b1; vld_in = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; cnt_ff <= 5'd0; vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in; cnt_ff <= cnt_in; vld_ff <= vld_in;
      end
   end
endmodule
`default_nettype wire

FILE: rtl/core/crv_checker.sv
// Port-level checker for the record validator, bound to the top level.
// Depends on crv_pkg.
`default_nettype none
module crv_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic req_read_failed,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic [2:0] rsp_status,
   input wire logic [1:0] rsp_active
);
   import crv_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("response changed while stalled");
   a_fail_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_read_failed |=> rsp_valid && rsp_status == ST_READ)
      else $error("read failure gave no read error result");
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= ST_READ)
      else $error("status out of range");
   a_active: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_active != 2'd3)
      else $error("active slot out of range");
endmodule

bind config_record_validator_unit crv_checker u_crv_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .req_read_failed(req.data.read_failed),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_status(rsp.data.record_status), .rsp_active(rsp.data.selected_slot)
);
`default_nettype wire

FILE: tb/sv/tb_top.sv
// Testbench for config_record_validator_unit: drives record words on the
// req channel, predicts each record result and checks every rsp transfer.
// Depends on crv_pkg, crv_if and the RTL of the unit.
`default_nettype none
module tb_top;
   import crv_pkg::*;

   class record_scoreboard;
      logic [15:0] schema;
      logic [2:0]  pos;
      logic [31:0] crc;
      logic [2:0]  fault;
      logic [31:0] gen_w, geom_w, align_w, flags_w;
      logic [1:0]  sel_slot;
      logic [31:0] sel_gen;
      logic [1:0]  mask;
      crv_rsp_type pending[$];
      int          mismatches;
      int          results_seen;
      int          ok_records;

      function void clear_record();
         pos = 0;
         crc = '1;
         fault = ST_OK;
      endfunction

      function void reset_state();
         schema = 16'd1;
         clear_record();
         gen_w = 0; geom_w = 0; align_w = 0; flags_w = 0;
         sel_slot = NO_SLOT; sel_gen = 0; mask = 0;
      endfunction

      function void flag(logic [2:0] code);
         if (fault == ST_OK || code < fault) fault = code;
      endfunction

      function logic [31:0] crc_fold(logic [31:0] c, logic [31:0] w);
         for (int b = 0; b < 32; b++) begin
            c = c ^ 32'(w[b]);
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
         end
         return c;
      endfunction

      function bit settings_consistent();
         logic [31:0] cpr, cyc, zpos, oq, den, rounded;
         int qe, dir, err;
         cpr = geom_w[15:0]; cyc = geom_w[31:16];
         zpos = align_w[15:0]; oq = align_w[31:16];
         qe = $signed(flags_w[15:0]);
         dir = $signed(flags_w[23:16]);
         if (cpr < 8 || cyc == 0) return 0;
         den = cyc * 4;
         if (den > cpr / 2) return 0;
         if (!flags_w[24]) return zpos == 0 && oq == 0 && qe == 0 && dir == 0;
         if (zpos >= cpr || oq == 0 || oq >= cpr / 2 || (dir != 1 && dir != -1))
            return 0;
         rounded = (cpr + den / 2) / den;
         err = int'(oq) - int'(rounded);
         return err == qe;
      endfunction

      function void note_word(crv_req_type r);
         crv_rsp_type e;
         logic [31:0] d;
         if (pos == 0 && r.new_scan) begin
            sel_slot = NO_SLOT; sel_gen = 0; mask = 0;
         end
         e = '0;
         e.record_slot = r.slot;
         if (r.read_failed) begin
            e.record_status = ST_READ;
            e.selected_slot = sel_slot;
            e.passed_slots = mask;
            pending.push_back(e);
            clear_record();
            return;
         end
         if (pos < REC_CRC_IDX) crc = crc_fold(crc, r.word);
         case (pos)
            3'd0: if (r.word != REC_MAGIC) flag(ST_MAGIC);
            3'd1: if (r.word[31:16] != schema || r.word[15:0] != REC_WORDS)
                     flag(ST_HEADER);
            3'd2: gen_w = r.word;
            3'd3: geom_w = r.word;
            3'd4: align_w = r.word;
            3'd5: begin
               flags_w = r.word;
               if ((r.word & REC_RESERVED) != 0) flag(ST_RESERVED);
            end
            3'd6: if (r.word != ~crc) flag(ST_CRC);
            default: if (r.word != REC_COMMIT) flag(ST_MAGIC);
         endcase
         if (pos != REC_LAST_IDX) begin
            pos++;
            return;
         end
         if (fault == ST_OK && !settings_consistent()) fault = ST_SETTINGS;
         if (fault == ST_OK) begin
            ok_records++;
            mask[r.slot] = 1'b1;
            d = gen_w - sel_gen;
            if (sel_slot == NO_SLOT || (d != 0 && d < 32'h80000000)) begin
               sel_slot = {1'b0, r.slot};
               sel_gen = gen_w;
            end
         end
         e.record_status = fault;
         e.generation = gen_w;
         e.counts_per_rev = geom_w[15:0];
         e.cycles_per_rev = geom_w[31:16];
         e.zero_position = align_w[15:0];
         e.observed_quarter = align_w[31:16];
         e.quarter_error = flags_w[15:0];
         e.direction = flags_w[23:16];
         e.alignment_valid = flags_w[24];
         e.selected_slot = sel_slot;
         e.passed_slots = mask;
         pending.push_back(e);
         clear_record();
      endfunction

      function void check_result(crv_rsp_type got);
         crv_rsp_type e;
         results_seen++;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", got);
            return;
         end
         e = pending.pop_front();
         if (got !== e) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p, got %p", e, got);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic csr_write_enable = 0;
   logic [15:0] csr_write_data = 0;
   crv_req_if req ();
   crv_rsp_if rsp ();
   record_scoreboard sb;
   int burst_left = 0;
   int words_sent = 0;

   config_record_validator_unit uut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   initial begin
      req.valid = 0;
      req.data = '0;
      rsp.ready = 0;
   end

   initial begin
      #20000000;
      $display("CHECKS FAILED");
      $finish;
   end

   // receiver stall pattern: ready is mostly high, with random stalls
   always @(posedge clock) begin
      if (rsp.valid && rsp.ready) sb.check_result(rsp.data);
      if (reset) rsp.ready <= 0;
      else case ($urandom_range(0, 9))
         0, 1: rsp.ready <= 0;
         2: rsp.ready <= ($urandom_range(0, 3) == 0);
         default: rsp.ready <= 1;
      endcase
   end

   // valid stays high across a burst; it drops only for a gap or a drain
   task automatic send_word(logic [31:0] w, logic s, logic fail, logic scan);
      crv_req_type r;
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 3) == 0 ? $urandom_range(1, 40) : 0;
         if (gap > 0) begin
            req.valid <= 0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      r = '{word: w, slot: s, read_failed: fail, new_scan: scan};
      req.valid <= 1;
      req.data <= r;
      do @(posedge clock); while (!req.ready);
      sb.note_word(r);
      words_sent++;
   endtask

   task automatic send_record(logic [31:0] rec[8], logic s, logic scan,
                              int fail_at);
      for (int i = 0; i < 8; i++) begin
         send_word(rec[i], s, i == fail_at, scan && i == 0);
         if (i == fail_at) return;
      end
   endtask

   function automatic logic [31:0] record_crc(logic [31:0] rec[8]);
      logic [31:0] c;
      c = '1;
      for (int i = 0; i < 6; i++) c = sb.crc_fold(c, rec[i]);
      return ~c;
   endfunction

   // consistent record content; variant picks alignment-invalid form
   task automatic build_record(output logic [31:0] rec[8], input logic [31:0] gen,
                               input bit aligned);
      logic [15:0] cpr, cyc, zpos, oq;
      logic [31:0] den, rounded;
      logic [7:0]  dir;
      cyc = $urandom_range(1, 50);
      cpr = $urandom_range(cyc * 8, 65535);
      den = cyc * 4;
      rounded = (cpr + den / 2) / den;
      oq = rounded + $urandom_range(0, 6) - 3;
      if (oq == 0) oq = 1;
      zpos = $urandom_range(0, cpr - 1);
      dir = $urandom_range(0, 1) ? 8'h01 : 8'hFF;
      rec[0] = REC_MAGIC;
      rec[1] = {sb.schema, REC_WORDS};
      rec[2] = gen;
      rec[3] = {cyc, cpr};
      if (aligned) begin
         rec[4] = {oq, zpos};
         rec[5] = {7'd0, 1'b1, dir, 16'(int'(oq) - int'(rounded))};
      end else begin
         rec[4] = 0;
         rec[5] = 0;
      end
      rec[6] = record_crc(rec);
      rec[7] = REC_COMMIT;
   endtask

   task automatic corrupt(ref logic [31:0] rec[8]);
      int k;
      k = $urandom_range(0, 9);
      case (k)
         0: rec[0] ^= 32'(1) << $urandom_range(0, 31);
         1: rec[7] ^= 32'(1) << $urandom_range(0, 31);
         2: rec[1] ^= 32'(1) << $urandom_range(0, 31);
         3: rec[6] ^= 32'(1) << $urandom_range(0, 31);
         4: begin
            rec[5] |= 32'(1) << $urandom_range(25, 31);
            rec[6] = record_crc(rec);
         end
         5, 6: begin
            rec[$urandom_range(3, 5)] ^= 32'(1) << $urandom_range(0, 31);
            rec[6] = record_crc(rec);
         end
         7: for (int i = 0; i < 8; i++) rec[i] = $urandom;
         default: begin
            rec[0] = $urandom;
            rec[5] = $urandom;
            rec[1] = $urandom;
         end
      endcase
   endtask

   task automatic wait_drained();
      req.valid <= 0;
      burst_left = 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic write_schema(logic [15:0] v);
      csr_write_enable <= 1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_enable <= 0;
      sb.schema = v;
      @(posedge clock);
   endtask

   initial begin
      logic [31:0] rec[8];
      logic [31:0] g;
      logic [15:0] schemas[4];
      sb = new();
      sb.reset_state();
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: good records in both slots, equal and wrapped serials
      build_record(rec, 32'h0, 1);          send_record(rec, 0, 1, -1);
      build_record(rec, 32'hFFFFFFFF, 0);   send_record(rec, 1, 0, -1);
      build_record(rec, 32'hFFFFFFFF, 1);   send_record(rec, 0, 0, -1);
      build_record(rec, 32'h7FFFFFFF, 1);   send_record(rec, 1, 1, -1);
      // multiple faults: magic and header and crc together
      build_record(rec, 5, 1); rec[0] = 0; rec[1] = '1; rec[6] = 0;
      send_record(rec, 0, 0, -1);
      // header and reserved bits
      build_record(rec, 6, 1); rec[1] = 0; rec[5] |= REC_RESERVED;
      rec[6] = record_crc(rec); send_record(rec, 1, 0, -1);
      // settings invalid with extreme field values
      for (int i = 0; i < 8; i++) rec[i] = '1;
      rec[0] = REC_MAGIC; rec[1] = {sb.schema, REC_WORDS}; rec[5] = 32'h01FFFFFF;
      rec[6] = record_crc(rec); rec[7] = REC_COMMIT;
      send_record(rec, 1, 0, -1);
      // read failures: first word with new_scan, middle, last
      build_record(rec, 9, 1); send_record(rec, 0, 1, 0);
      send_record(rec, 1, 0, 4);
      send_record(rec, 0, 0, 7);
      wait_drained();

      schemas = '{16'h0000, 16'hFFFF, 16'h8001, 16'h0001};
      for (int ph = 0; ph < 4; ph++) begin
         write_schema(schemas[ph]);
         g = $urandom;
         while (words_sent < (ph + 1) * 220 + 70) begin
            build_record(rec, g + $urandom_range(0, 6) - 2, $urandom_range(0, 4) != 0);
            if ($urandom_range(0, 3) == 0) corrupt(rec);
            send_record(rec, $urandom_range(0, 1), $urandom_range(0, 5) == 0,
                        $urandom_range(0, 12) == 0 ? $urandom_range(0, 7) : -1);
            if ($urandom_range(0, 9) == 0) g = $urandom;
            else g += $urandom_range(0, 3);
         end
         // partial record left open is fine only before a drain; end it with a read failure
         while (sb.pos != 0) send_word(REC_COMMIT, 0, 1, 0);
         wait_drained();
      end

      $display("sent %0d words, checked %0d results (%0d valid records)",
               words_sent, sb.results_seen, sb.ok_records);
      if (sb.mismatches == 0 && sb.pending.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end
endmodule
`default_nettype wire

FILE: sim.f
rtl/core/crv_pkg.sv
rtl/core/crv_if.sv
rtl/core/crv_datapath.sv
rtl/core/crv_ctrl.sv
rtl/core/config_record_validator_unit.sv
rtl/core/crv_checker.sv
tb/sv/tb_top.sv
